// ===== design/mfep_pkg.sv =====
// Shared types, codes and constants of the MIDI file track event parser.
`timescale 1ns / 1ps
`default_nettype none

package mfep_pkg;

  // Longest variable-length field accepted without an overlong error.
  localparam int VLV_MAX_BYTES = 4;

  // Byte values that steer the parse.
  localparam logic [7:0] DATA_MASK      = 8'h7F;
  localparam logic [7:0] STATUS_FLAG    = 8'h80;
  localparam logic [7:0] CHAN_LAST      = 8'hEF;
  localparam logic [7:0] META_STATUS    = 8'hFF;
  localparam logic [7:0] META_SET_TEMPO = 8'h51;

  // Saturation limits of the length and delta fields.
  localparam logic [27:0] VLV_SAT       = 28'hFFFFFFF;
  localparam logic [27:0] VLV_SHIFT_MAX = 28'h01FFFFF;

  // Event kinds.
  localparam logic [3:0] KIND_NOTE_OFF   = 4'd0;
  localparam logic [3:0] KIND_NOTE_ON    = 4'd1;
  localparam logic [3:0] KIND_AFTERTOUCH = 4'd2;
  localparam logic [3:0] KIND_CONTROL    = 4'd3;
  localparam logic [3:0] KIND_PROGRAM    = 4'd4;
  localparam logic [3:0] KIND_PRESSURE   = 4'd5;
  localparam logic [3:0] KIND_PITCH      = 4'd6;
  localparam logic [3:0] KIND_SYSEX      = 4'd7;
  localparam logic [3:0] KIND_META       = 4'd8;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_STATUS = 2'd1;
  localparam logic [1:0] ERR_SHORT_TMP = 2'd2;
  localparam logic [1:0] ERR_OVERLONG  = 2'd3;

  // Parse phases.
  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_MTYPE,
    PH_LEN,
    PH_SKIP
  } phase_t;

  // One finished event.
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  status;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic [7:0]  meta_type;
    logic [27:0] length;
    logic [23:0] tempo;
    logic        tempo_valid;
    logic [27:0] delta;
    logic [1:0]  err;
  } result_t;

endpackage

`default_nettype wire

// ===== design/mfep_parser.sv =====
// Byte-wise parse state machine that turns track bytes into finished events.
`timescale 1ns / 1ps
`default_nettype none

module mfep_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               byte_valid,
  input  wire logic [7:0]         data_byte,
  input  wire logic               track_start,
  output logic                    res_valid,
  output mfep_pkg::result_t       res
);

  mfep_pkg::phase_t phase_r, phase_nxt;
  logic [27:0] vlv_acc_r, vlv_acc_nxt;
  logic [2:0]  vlv_cnt_r, vlv_cnt_nxt;
  logic [27:0] delta_r, delta_nxt;
  logic [7:0]  cur_status_r, cur_status_nxt;
  logic [7:0]  run_status_r, run_status_nxt;
  logic [6:0]  first_r, first_nxt;
  logic [7:0]  meta_kind_r, meta_kind_nxt;
  logic [27:0] left_r, left_nxt;
  logic [23:0] tempo_acc_r, tempo_acc_nxt;
  logic [1:0]  tempo_idx_r, tempo_idx_nxt;
  logic [1:0]  err_r, err_nxt;

  logic [2:0]  vlv_cnt_step;
  logic [27:0] vlv_acc_step;
  logic        vlv_done;
  logic        take_d1;
  logic        fin_long;
  logic        do_emit;
  logic [3:0]  chan_kind;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mfep_pkg::PH_DELTA;
      vlv_acc_r    <= '0;
      vlv_cnt_r    <= '0;
      delta_r      <= '0;
      cur_status_r <= '0;
      run_status_r <= '0;
      first_r      <= '0;
      meta_kind_r  <= '0;
      left_r       <= '0;
      tempo_acc_r  <= '0;
      tempo_idx_r  <= '0;
      err_r        <= '0;
    end else begin
      phase_r      <= phase_nxt;
      vlv_acc_r    <= vlv_acc_nxt;
      vlv_cnt_r    <= vlv_cnt_nxt;
      delta_r      <= delta_nxt;
      cur_status_r <= cur_status_nxt;
      run_status_r <= run_status_nxt;
      first_r      <= first_nxt;
      meta_kind_r  <= meta_kind_nxt;
      left_r       <= left_nxt;
      tempo_acc_r  <= tempo_acc_nxt;
      tempo_idx_r  <= tempo_idx_nxt;
      err_r        <= err_nxt;
    end
  end

  // Next state and result for the byte of the current transaction.
  always_comb begin
    phase_nxt      = phase_r;
    vlv_acc_nxt    = vlv_acc_r;
    vlv_cnt_nxt    = vlv_cnt_r;
    delta_nxt      = delta_r;
    cur_status_nxt = cur_status_r;
    run_status_nxt = run_status_r;
    first_nxt      = first_r;
    meta_kind_nxt  = meta_kind_r;
    left_nxt       = left_r;
    tempo_acc_nxt  = tempo_acc_r;
    tempo_idx_nxt  = tempo_idx_r;
    err_nxt        = err_r;
    res            = '0;
    take_d1        = 1'b0;
    fin_long       = 1'b0;
    do_emit        = 1'b0;
    vlv_cnt_step   = '0;
    vlv_acc_step   = '0;
    vlv_done       = 1'b0;
    chan_kind      = '0;

    if (byte_valid) begin
      // A track start clears everything before the byte is looked at.
      if (track_start) begin
        phase_nxt      = mfep_pkg::PH_DELTA;
        vlv_acc_nxt    = '0;
        vlv_cnt_nxt    = '0;
        delta_nxt      = '0;
        cur_status_nxt = '0;
        run_status_nxt = '0;
        first_nxt      = '0;
        meta_kind_nxt  = '0;
        left_nxt       = '0;
        tempo_acc_nxt  = '0;
        tempo_idx_nxt  = '0;
        err_nxt        = '0;
      end

      // One step of a variable-length field, used by delta and length.
      vlv_cnt_step = (vlv_cnt_nxt < 3'd7) ? vlv_cnt_nxt + 3'd1 : vlv_cnt_nxt;
      vlv_acc_step = (vlv_acc_nxt > mfep_pkg::VLV_SHIFT_MAX) ? mfep_pkg::VLV_SAT :
                     {vlv_acc_nxt[20:0], data_byte[6:0]};
      vlv_done     = !data_byte[7];

      case (phase_nxt)
        mfep_pkg::PH_DELTA: begin
          vlv_cnt_nxt = vlv_cnt_step;
          vlv_acc_nxt = vlv_acc_step;
          if (int'(vlv_cnt_step) > mfep_pkg::VLV_MAX_BYTES && err_nxt == mfep_pkg::ERR_NONE) begin
            err_nxt = mfep_pkg::ERR_OVERLONG;
          end
          if (vlv_done) begin
            delta_nxt   = vlv_acc_step;
            vlv_acc_nxt = '0;
            vlv_cnt_nxt = '0;
            phase_nxt   = mfep_pkg::PH_STATUS;
          end
        end
        mfep_pkg::PH_STATUS: begin
          if ((data_byte & mfep_pkg::STATUS_FLAG) != 8'h00) begin
            cur_status_nxt = data_byte;
            vlv_acc_nxt    = '0;
            vlv_cnt_nxt    = '0;
            if (data_byte <= mfep_pkg::CHAN_LAST) begin
              run_status_nxt = data_byte;
              phase_nxt      = mfep_pkg::PH_DATA1;
            end else if (data_byte == mfep_pkg::META_STATUS) begin
              run_status_nxt = '0;
              phase_nxt      = mfep_pkg::PH_MTYPE;
            end else begin
              run_status_nxt = '0;
              phase_nxt      = mfep_pkg::PH_LEN;
            end
          end else if (run_status_nxt == 8'h00) begin
            // Data byte with nothing to run on: report and drop it.
            res.delta = delta_nxt;
            res.err   = mfep_pkg::ERR_NO_STATUS;
            do_emit   = 1'b1;
          end else begin
            cur_status_nxt = run_status_nxt;
            take_d1        = 1'b1;
          end
        end
        mfep_pkg::PH_DATA1: begin
          take_d1 = 1'b1;
        end
        mfep_pkg::PH_DATA2: begin
          res.kind     = cur_status_nxt[7:4] - 4'd8;
          res.status   = cur_status_nxt;
          res.data_one = first_nxt;
          res.data_two = data_byte[6:0];
          res.delta    = delta_nxt;
          res.err      = err_nxt;
          do_emit      = 1'b1;
        end
        mfep_pkg::PH_MTYPE: begin
          meta_kind_nxt = data_byte;
          vlv_acc_nxt   = '0;
          vlv_cnt_nxt   = '0;
          phase_nxt     = mfep_pkg::PH_LEN;
        end
        mfep_pkg::PH_LEN: begin
          vlv_cnt_nxt = vlv_cnt_step;
          vlv_acc_nxt = vlv_acc_step;
          if (int'(vlv_cnt_step) > mfep_pkg::VLV_MAX_BYTES && err_nxt == mfep_pkg::ERR_NONE) begin
            err_nxt = mfep_pkg::ERR_OVERLONG;
          end
          if (vlv_done) begin
            left_nxt = vlv_acc_step;
            if (vlv_acc_step == 28'd0) begin
              fin_long = 1'b1;
            end else begin
              phase_nxt = mfep_pkg::PH_SKIP;
            end
          end
        end
        mfep_pkg::PH_SKIP: begin
          // Capture the first three payload bytes of a set-tempo event.
          if (cur_status_nxt == mfep_pkg::META_STATUS &&
              meta_kind_nxt == mfep_pkg::META_SET_TEMPO && tempo_idx_nxt < 2'd3) begin
            tempo_acc_nxt = {tempo_acc_nxt[15:0], data_byte};
            tempo_idx_nxt = tempo_idx_nxt + 2'd1;
          end
          if (left_nxt != 28'd0) begin
            left_nxt = left_nxt - 28'd1;
          end
          if (left_nxt == 28'd0) begin
            fin_long = 1'b1;
          end
        end
        default: begin
          phase_nxt = mfep_pkg::PH_DELTA;
        end
      endcase

      // First data byte of a channel message.
      if (take_d1) begin
        chan_kind = cur_status_nxt[7:4] - 4'd8;
        first_nxt = data_byte[6:0];
        if (chan_kind == mfep_pkg::KIND_PROGRAM || chan_kind == mfep_pkg::KIND_PRESSURE) begin
          res.kind     = chan_kind;
          res.status   = cur_status_nxt;
          res.data_one = first_nxt;
          res.delta    = delta_nxt;
          res.err      = err_nxt;
          do_emit      = 1'b1;
        end else begin
          phase_nxt = mfep_pkg::PH_DATA2;
        end
      end

      // End of a sysex or meta event.
      if (fin_long) begin
        res.length = vlv_acc_nxt;
        res.delta  = delta_nxt;
        if (cur_status_nxt != mfep_pkg::META_STATUS) begin
          res.kind   = mfep_pkg::KIND_SYSEX;
          res.status = cur_status_nxt;
        end else begin
          res.kind      = mfep_pkg::KIND_META;
          res.status    = mfep_pkg::META_STATUS;
          res.meta_type = meta_kind_nxt;
          if (meta_kind_nxt == mfep_pkg::META_SET_TEMPO) begin
            if (tempo_idx_nxt < 2'd3) begin
              if (err_nxt == mfep_pkg::ERR_NONE) begin
                err_nxt = mfep_pkg::ERR_SHORT_TMP;
              end
            end else if (err_nxt == mfep_pkg::ERR_NONE) begin
              res.tempo_valid = 1'b1;
              res.tempo       = tempo_acc_nxt;
            end
          end
        end
        res.err = err_nxt;
        do_emit = 1'b1;
      end

      // A finished event starts the next one from a clean slate.
      if (do_emit) begin
        phase_nxt      = mfep_pkg::PH_DELTA;
        vlv_acc_nxt    = '0;
        vlv_cnt_nxt    = '0;
        delta_nxt      = '0;
        cur_status_nxt = '0;
        first_nxt      = '0;
        meta_kind_nxt  = '0;
        left_nxt       = '0;
        tempo_acc_nxt  = '0;
        tempo_idx_nxt  = '0;
        err_nxt        = '0;
      end
    end
  end

  assign res_valid = do_emit;

endmodule

`default_nettype wire

// ===== design/mfep_out_buf.sv =====
// Result register with a skid stage, so the parser keeps taking bytes under a stall.
`timescale 1ns / 1ps
`default_nettype none

module mfep_out_buf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               res_valid,
  input  mfep_pkg::result_t       res,
  output logic                    space,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mfep_pkg::result_t       out_res
);

  logic              main_v_r;
  logic              skid_v_r;
  mfep_pkg::result_t main_r;
  mfep_pkg::result_t skid_r;
  logic              main_free;

  assign main_free = !main_v_r || out_ready;
  assign space     = !skid_v_r;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (main_free) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_r <= skid_v_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid = main_v_r;
  assign out_res   = main_r;

endmodule

`default_nettype wire

// ===== design/midi_file_event_parser.sv =====
// Top level of the MIDI file track event parser.
//
//  Channel  Ports                      Width  Contents
//  input    in_tvalid/tready/tdata     8      data_byte
//           in_tuser                   1      track_start
//  output   out_tvalid/tready/tdata    112    event fields, see port list
//           out_tuser                  5      event_kind, tempo_valid
//
// One byte is taken per cycle while in_tready is high; each byte is settled in
// the cycle it arrives, and a finished event is registered in the result or skid stage.
// Reset is synchronous and active low; it clears the parse state and the
// running status. in_tready falls only while the skid stage holds an event,
// that is after two events have piled up behind a stalled output.
`timescale 1ns / 1ps
`default_nettype none

module midi_file_event_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tuser,   // [0] track_start
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [7:0] status_byte, [14:8] data_one, [21:15] data_two, [29:22] meta_type,
  // [57:30] payload_length, [81:58] tempo_value, [109:82] delta_time,
  // [111:110] error_code
  output logic [111:0]      out_tdata,
  output logic [4:0]        out_tuser   // [3:0] event_kind, [4] tempo_valid
);

  logic              in_fire;
  logic              res_valid;
  logic              space;
  mfep_pkg::result_t res;
  mfep_pkg::result_t out_res;

  assign in_tready = space;
  assign in_fire   = in_tvalid && space;

  // Parse state machine.
  mfep_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (in_fire),
    .data_byte   (in_tdata),
    .track_start (in_tuser),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register and skid stage.
  mfep_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the result transaction.
  assign out_tdata = {out_res.err, out_res.delta, out_res.tempo, out_res.length,
                      out_res.meta_type, out_res.data_two, out_res.data_one,
                      out_res.status};
  assign out_tuser = {out_res.tempo_valid, out_res.kind};

endmodule

`default_nettype wire

// ===== design/mfep_checker.sv =====
// Port-level checks of the MIDI file track event parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mfep_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [7:0]   in_tdata,
  input wire logic         in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [111:0] out_tdata,
  input wire logic [4:0]   out_tuser
);

  // A result that waits is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction withdrawn under stall");

  // No result straight after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // A valid tempo only comes with an error-free meta event.
  a_tempo_meta: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4] |->
      out_tuser[3:0] == mfep_pkg::KIND_META && out_tdata[111:110] == mfep_pkg::ERR_NONE)
    else $error("tempo flagged on a non-meta or failed event");

  // A missing status leaves every field zero but the delta time and error code.
  a_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[111:110] == mfep_pkg::ERR_NO_STATUS |->
      out_tuser == 5'd0 && out_tdata[81:0] == 82'd0)
    else $error("missing-status event carries data");

  // The input side stalls only while a result is pending.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with the output empty");

endmodule

bind midi_file_event_parser mfep_checker u_mfep_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/mfep_event_checker.sv =====
// Checker for the MIDI file track event parser: it predicts each event and compares it.
`timescale 1ns / 1ps

module mfep_event_checker
  import mfep_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] track_start
  input  logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] status_byte, [14:8] data_one, [21:15] data_two, [29:22] meta_type,
  // [57:30] payload_length, [81:58] tempo_value, [109:82] delta_time,
  // [111:110] error_code
  input  logic [111:0] out_tdata,
  input  logic [4:0]   out_tuser,  // [3:0] event_kind, [4] tempo_valid
  output int           fail_count,
  output int           events_pending,
  output int           events_checked
);

  // A field of 28 bits saturates here; the shift stops once it would lose bits.
  localparam logic [27:0] FIELD_SAT   = 28'hFFFFFFF;
  localparam logic [27:0] SHIFT_LIMIT = 28'h01FFFFF;

  // Mirror of the parse state.
  phase_t      phase;
  logic [27:0] vlv_acc;
  logic [2:0]  vlv_cnt;
  logic [27:0] delta_ticks;
  logic [7:0]  cur_status;
  logic [7:0]  run_status;
  logic [6:0]  first_data;
  logic [7:0]  meta_kind;
  logic [27:0] bytes_left;
  logic [23:0] tempo_acc;
  logic [1:0]  tempo_idx;
  logic [1:0]  err_pending;

  // Events predicted but not yet seen on the output channel, oldest first.
  result_t expected_events[$];

  function automatic void clear_event();
    phase       = PH_DELTA;
    vlv_acc     = '0;
    vlv_cnt     = '0;
    delta_ticks = '0;
    cur_status  = '0;
    first_data  = '0;
    meta_kind   = '0;
    bytes_left  = '0;
    tempo_acc   = '0;
    tempo_idx   = '0;
    err_pending = ERR_NONE;
  endfunction

  // Only the first error of an event is kept.
  function automatic void note_err(logic [1:0] code);
    if (err_pending == ERR_NONE) begin
      err_pending = code;
    end
  endfunction

  // Takes one byte of a variable-length field; returns 1 on its last byte.
  function automatic logic take_vlv(logic [7:0] b);
    if (vlv_cnt < 3'd7) begin
      vlv_cnt++;
    end
    if (vlv_cnt > VLV_MAX_BYTES) begin
      note_err(ERR_OVERLONG);
    end
    if (vlv_acc > SHIFT_LIMIT) begin
      vlv_acc = FIELD_SAT;
    end else begin
      vlv_acc = {vlv_acc[20:0], b[6:0]};
    end
    return !b[7];
  endfunction

  function automatic void push_event(logic [3:0] kind, logic [7:0] status,
                                     logic [6:0] d1, logic [6:0] d2,
                                     logic [7:0] mtype, logic [27:0] len,
                                     logic [23:0] tempo, logic tvalid,
                                     logic [1:0] err);
    result_t ev;
    ev.kind        = kind;
    ev.status      = status;
    ev.data_one    = d1;
    ev.data_two    = d2;
    ev.meta_type   = mtype;
    ev.length      = len;
    ev.tempo       = tempo;
    ev.tempo_valid = tvalid;
    ev.delta       = delta_ticks;
    ev.err         = err;
    expected_events.push_back(ev);
    clear_event();
  endfunction

  function automatic logic [3:0] chan_kind(logic [7:0] status);
    return status[7:4] - 4'd8;
  endfunction

  // Closes a sysex or meta event once its payload has been skipped.
  function automatic void finish_long();
    logic        tvalid;
    logic [23:0] tempo;
    tvalid = 1'b0;
    tempo  = '0;
    if (cur_status != META_STATUS) begin
      push_event(KIND_SYSEX, cur_status, '0, '0, '0, vlv_acc, '0, 1'b0, err_pending);
    end else begin
      if (meta_kind == META_SET_TEMPO) begin
        if (tempo_idx < 2'd3) begin
          note_err(ERR_SHORT_TMP);
        end else if (err_pending == ERR_NONE) begin
          tvalid = 1'b1;
          tempo  = tempo_acc;
        end
      end
      push_event(KIND_META, META_STATUS, '0, '0, meta_kind, vlv_acc, tempo, tvalid,
                 err_pending);
    end
  endfunction

  // First data byte of a channel message; program and pressure end here.
  function automatic void take_first(logic [7:0] b);
    logic [3:0] kind;
    kind       = chan_kind(cur_status);
    first_data = b[6:0];
    if (kind == KIND_PROGRAM || kind == KIND_PRESSURE) begin
      push_event(kind, cur_status, first_data, '0, '0, '0, '0, 1'b0, err_pending);
    end else begin
      phase = PH_DATA2;
    end
  endfunction

  // Advances the predicted parse by one track byte.
  function automatic void parse_byte(logic [7:0] b, logic start);
    if (start) begin
      clear_event();
      run_status = '0;
    end
    case (phase)
      PH_STATUS: begin
        if (b[7]) begin
          cur_status = b;
          vlv_acc    = '0;
          vlv_cnt    = '0;
          if (b <= CHAN_LAST) begin
            run_status = b;
            phase      = PH_DATA1;
          end else if (b == META_STATUS) begin
            run_status = '0;
            phase      = PH_MTYPE;
          end else begin
            run_status = '0;
            phase      = PH_LEN;
          end
        end else if (run_status == '0) begin
          push_event(KIND_NOTE_OFF, '0, '0, '0, '0, '0, '0, 1'b0, ERR_NO_STATUS);
        end else begin
          cur_status = run_status;
          take_first(b);
        end
      end
      PH_DATA1: begin
        take_first(b);
      end
      PH_DATA2: begin
        push_event(chan_kind(cur_status), cur_status, first_data, b[6:0], '0, '0, '0,
                   1'b0, err_pending);
      end
      PH_MTYPE: begin
        meta_kind = b;
        vlv_acc   = '0;
        vlv_cnt   = '0;
        phase     = PH_LEN;
      end
      PH_LEN: begin
        if (take_vlv(b)) begin
          bytes_left = vlv_acc;
          if (bytes_left == '0) begin
            finish_long();
          end else begin
            phase = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (cur_status == META_STATUS && meta_kind == META_SET_TEMPO &&
            tempo_idx < 2'd3) begin
          tempo_acc = {tempo_acc[15:0], b};
          tempo_idx++;
        end
        if (bytes_left != '0) begin
          bytes_left--;
        end
        if (bytes_left == '0) begin
          finish_long();
        end
      end
      default: begin
        if (take_vlv(b)) begin
          delta_ticks = vlv_acc;
          vlv_acc     = '0;
          vlv_cnt     = '0;
          phase       = PH_STATUS;
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [27:0] want, logic [27:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Output transactions are checked before the input transaction of the same
  // edge is predicted, since an event never leaves in the cycle its byte enters.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      clear_event();
      run_status = '0;
      expected_events.delete();
      fail_count     = 0;
      events_checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind        = out_tuser[3:0];
        got.tempo_valid = out_tuser[4];
        got.status      = out_tdata[7:0];
        got.data_one    = out_tdata[14:8];
        got.data_two    = out_tdata[21:15];
        got.meta_type   = out_tdata[29:22];
        got.length      = out_tdata[57:30];
        got.tempo       = out_tdata[81:58];
        got.delta       = out_tdata[109:82];
        got.err         = out_tdata[111:110];
        if (expected_events.size() == 0) begin
          $error("event with kind %0d and status 0x%0h arrived with none predicted",
                 got.kind, got.status);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", want.kind, got.kind);
          check_field("status_byte", want.status, got.status);
          check_field("data_one", want.data_one, got.data_one);
          check_field("data_two", want.data_two, got.data_two);
          check_field("meta_type", want.meta_type, got.meta_type);
          check_field("payload_length", want.length, got.length);
          check_field("tempo_value", want.tempo, got.tempo);
          check_field("tempo_valid", want.tempo_valid, got.tempo_valid);
          check_field("delta_time", want.delta, got.delta);
          check_field("error_code", want.err, got.err);
          events_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, in_tuser);
      end
    end
    events_pending = expected_events.size();
  end

endmodule

// ===== tb/tb_midi_file_event_parser.sv =====
// Testbench top for the MIDI file track event parser: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_midi_file_event_parser;
  import mfep_pkg::*;

  // Directed opening; bit 8 marks the start of a track.
  localparam int INTRO_LEN = 42;
  localparam logic [8:0] INTRO [INTRO_LEN] = '{
    // Track start, note off with the data extremes.
    9'h100, 9'h080, 9'h000, 9'h07F,
    // Delta of 127, then a note off reusing the running status.
    9'h07F, 9'h000, 9'h07F,
    // Program change whose data byte has bit 7 set.
    9'h000, 9'h0C5, 9'h0FF,
    // Overlong length field of value zero: empty sysex, which drops running status.
    9'h000, 9'h0F7, 9'h080, 9'h080, 9'h080, 9'h080, 9'h000,
    // Data byte with no running status kept.
    9'h000, 9'h040,
    // Largest four-byte delta, then set tempo 0x07A120.
    9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h0FF, 9'h051, 9'h003, 9'h007, 9'h0A1, 9'h020,
    // Set tempo with a single payload byte.
    9'h000, 9'h0FF, 9'h051, 9'h001, 9'h0AA,
    // Five-byte delta that saturates, then an empty end-of-track meta.
    9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h0FF, 9'h02F, 9'h000
  };

  localparam int PHASE_BYTES = 112;
  localparam int IDLE_PCT [4]  = '{0, 53, 0, 18};
  localparam int STALL_PCT [4] = '{0, 0, 53, 18};

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'h00;
  logic         in_tuser   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [4:0]   out_tuser;

  int fail_count;
  int events_pending;
  int events_checked;

  int         src_idle   = 0;
  int         sink_stall = 0;
  int         sent_bytes = 0;
  logic       chan_ok    = 1'b0;
  logic [7:0] last_chan  = 8'h80;

  midi_file_event_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  mfep_event_checker CHK (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .fail_count     (fail_count),
    .events_pending (events_pending),
    .events_checked (events_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall);
  end

  // Hard stop in case the block hangs.
  initial begin
    #3ms;
    $display("TB_ERROR");
    $finish;
  end

  // Offers one byte, with random idle cycles first, and waits for its transaction.
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    sent_bytes++;
  endtask

  // Sends a variable-length field in n groups of 7 bits, most significant first.
  task automatic put_vlv(input int unsigned val, input int n, input logic start);
    logic [7:0] b;
    for (int i = n - 1; i >= 0; i--) begin
      b    = 8'((val >> (7 * i)) & 32'h7F);
      b[7] = (i != 0);
      send_byte(b, start && (i == n - 1));
    end
  endtask

  // Length field, padded now and then beyond the allowed size.
  task automatic put_length(input int len);
    put_vlv(len, ($urandom_range(19) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 2),
            1'b0);
  endtask

  task automatic put_payload(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  function automatic logic [7:0] data_value();
    return ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(127));
  endfunction

  // One well-formed event with random content, or now and then a stray byte.
  task automatic gen_event();
    logic       start;
    logic [7:0] st;
    logic [7:0] b;
    logic [7:0] mtype;
    int         r;
    int         n;
    int         len;
    start = ($urandom_range(99) < 4);
    if (start) begin
      chan_ok = 1'b0;
    end
    r = $urandom_range(99);
    if (r >= 92) begin
      send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
      return;
    end

    // Delta time: mostly one byte, sometimes up to four, rarely overlong.
    if ($urandom_range(99) < 6) begin
      n = $urandom_range(5, 7);
      for (int i = 0; i < n; i++) begin
        b    = 8'($urandom_range(255));
        b[7] = (i != n - 1);
        send_byte(b, start && (i == 0));
      end
    end else begin
      n = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1;
      put_vlv($urandom, n, start);
    end

    if (r < 55) begin
      // Channel message, reusing the running status about a third of the time.
      if (chan_ok && $urandom_range(2) == 0) begin
        st = last_chan;
      end else begin
        st = 8'(8'h80 + $urandom_range(8'h6F));
        send_byte(st, 1'b0);
      end
      last_chan = st;
      chan_ok   = 1'b1;
      send_byte(data_value(), 1'b0);
      if (st[7:4] != 4'hC && st[7:4] != 4'hD) begin
        send_byte(data_value(), 1'b0);
      end
    end else if (r < 75) begin
      // Meta event, set tempo being the commonest.
      mtype = ($urandom_range(2) == 0) ? META_SET_TEMPO : 8'($urandom_range(255));
      if (mtype == META_SET_TEMPO && $urandom_range(1) == 0) begin
        len = 3;
      end else begin
        len = $urandom_range(6);
      end
      send_byte(META_STATUS, 1'b0);
      send_byte(mtype, 1'b0);
      put_length(len);
      put_payload(len);
      chan_ok = 1'b0;
    end else begin
      // System status from F0 to FE, parsed as sysex, with a short payload.
      len = $urandom_range(6);
      send_byte(8'(8'hF0 + $urandom_range(14)), 1'b0);
      put_length(len);
      put_payload(len);
      chan_ok = 1'b0;
    end
  endtask

  initial begin
    int guard;
    int phase_start;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening with no idling on either side.
    for (int i = 0; i < INTRO_LEN; i++) begin
      send_byte(INTRO[i][7:0], INTRO[i][8]);
    end

    // Random events through the four flow-control phases.
    for (int p = 0; p < 4; p++) begin
      src_idle    = IDLE_PCT[p];
      sink_stall  = STALL_PCT[p];
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < PHASE_BYTES) begin
        gen_event();
      end
    end
    in_tvalid <= 1'b0;

    // Let every predicted event drain out.
    guard = 0;
    while (events_pending != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);

    if (events_pending != 0) begin
      $error("%0d predicted events never arrived", events_pending);
    end
    $display("Sent %0d track bytes, directed and random, under four flow-control phases.",
             sent_bytes);
    $display("Checked %0d parsed events field by field; %0d mismatches.",
             events_checked, fail_count);
    if (fail_count == 0 && events_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
